// ===== hdl/eft_pkg.sv =====
`default_nettype none
package eft_pkg;

    localparam int OUT_COORD_W = 12;
    localparam int ITER_W      = 9;
    localparam int COLOR_W     = 8;
    localparam int VAL_W       = 32;
    localparam int STEP_W      = 31;
    localparam int CFG_IDX_W   = 8;
    localparam int DIV_STEPS   = 9;

    localparam int DEF_MAX_ITER_CELLS = 256;
    localparam int DEF_COORD_BITS     = 12;
    localparam int DEF_FRAC_BITS      = 28;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 8'd3;

    localparam logic [VAL_W-1:0]  RST_ORIGIN_RE  = 32'hE000_0000;
    localparam logic [VAL_W-1:0]  RST_ORIGIN_IM  = 32'h1000_0000;
    localparam logic [STEP_W-1:0] RST_PIXEL_STEP = 31'h0010_0000;
    localparam logic [ITER_W-1:0] RST_MAX_ITER   = 9'd256;

    localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

    // Per-pixel control that travels down the chain with the data.
    typedef struct packed {
        logic                   valid;
        logic                   done;
        logic [OUT_COORD_W-1:0] col;
        logic [OUT_COORD_W-1:0] row;
    } eft_tag_t;

    // Clamp a 65-bit signed value to the 32-bit signed range.
    function automatic logic [VAL_W-1:0] sat32(input logic signed [64:0] v);
        logic [VAL_W-1:0] r;
        if (v > 65'sh0_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -65'sh0_8000_0000)
            r = 32'h8000_0000;
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/escape_time_fractal_pixel.sv =====
// Channel  Direction  Handshake            Word
// in       input      in_valid / in_stall   pixel_col, pixel_row
// out      output     out_valid / out_stall out_col, out_row, iter_count, red, green, blue
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel enters per cycle while in_stall is low.
// The pipeline is the map stages, the chain of iteration cells, two stages per cell, and the color stages.
// A stall on the output while out_valid is high freezes the whole chain and holds the result; in_stall follows it.
// Reset clears the valid marks in every stage and loads the default view registers.
`default_nettype none
module escape_time_fractal_pixel #(
    parameter int MAX_ITER_CELLS = eft_pkg::DEF_MAX_ITER_CELLS,
    parameter int COORD_BITS     = eft_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS      = eft_pkg::DEF_FRAC_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [COORD_BITS-1:0]             pixel_col,
    input  wire logic [COORD_BITS-1:0]             pixel_row,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [eft_pkg::OUT_COORD_W-1:0]        out_col,
    output logic [eft_pkg::OUT_COORD_W-1:0]        out_row,
    output logic [eft_pkg::ITER_W-1:0]             iter_count,
    output logic [eft_pkg::COLOR_W-1:0]            red,
    output logic [eft_pkg::COLOR_W-1:0]            green,
    output logic [eft_pkg::COLOR_W-1:0]            blue,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [eft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [eft_pkg::VAL_W-1:0]         cfg_data
);
    import eft_pkg::*;

    localparam int NW = $clog2(MAX_ITER_CELLS + 1);

    logic [VAL_W-1:0]  origin_re_reg, origin_im_reg;
    logic [STEP_W-1:0] pixel_step_reg;
    logic [ITER_W-1:0] max_iter_reg;
    logic [NW-1:0]     lim;
    logic              en;

    assign cfg_ready = 1'b1;
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg  <= RST_ORIGIN_RE;
            origin_im_reg  <= RST_ORIGIN_IM;
            pixel_step_reg <= RST_PIXEL_STEP;
            max_iter_reg   <= RST_MAX_ITER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ORIGIN_RE:  origin_re_reg  <= cfg_data;
                REG_ORIGIN_IM:  origin_im_reg  <= cfg_data;
                REG_PIXEL_STEP: pixel_step_reg <= cfg_data[STEP_W-1:0];
                REG_MAX_ITER:   max_iter_reg   <= cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // A limit of zero acts as one; a limit above the chain length is cut to it.
    always_comb
    begin
        if (max_iter_reg == '0)
            lim = NW'(1);
        else if (32'(max_iter_reg) > 32'(MAX_ITER_CELLS))
            lim = NW'(MAX_ITER_CELLS);
        else
            lim = NW'(max_iter_reg);
    end

    eft_tag_t         tag_w [0:MAX_ITER_CELLS];
    logic [VAL_W-1:0] cre_w [0:MAX_ITER_CELLS];
    logic [VAL_W-1:0] cim_w [0:MAX_ITER_CELLS];
    logic [VAL_W-1:0] zre_w [0:MAX_ITER_CELLS];
    logic [VAL_W-1:0] zim_w [0:MAX_ITER_CELLS];
    logic [NW-1:0]    n_w   [0:MAX_ITER_CELLS];

    eft_map #(
        .COORD_BITS (COORD_BITS),
        .NW         (NW)
    ) u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_fire    (in_valid && !in_stall),
        .col        (pixel_col),
        .row        (pixel_row),
        .origin_re  (origin_re_reg),
        .origin_im  (origin_im_reg),
        .pixel_step (pixel_step_reg),
        .tag_o      (tag_w[0]),
        .cre_o      (cre_w[0]),
        .cim_o      (cim_w[0]),
        .n_o        (n_w[0])
    );

    // The iteration starts from z = c.
    assign zre_w[0] = cre_w[0];
    assign zim_w[0] = cim_w[0];

    for (genvar k = 0; k < MAX_ITER_CELLS; k++)
    begin : g_cell
        eft_cell #(
            .FRAC_BITS (FRAC_BITS),
            .NW        (NW)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .lim   (lim),
            .tag_i (tag_w[k]),
            .cre_i (cre_w[k]),
            .cim_i (cim_w[k]),
            .zre_i (zre_w[k]),
            .zim_i (zim_w[k]),
            .n_i   (n_w[k]),
            .tag_o (tag_w[k+1]),
            .cre_o (cre_w[k+1]),
            .cim_o (cim_w[k+1]),
            .zre_o (zre_w[k+1]),
            .zim_o (zim_w[k+1]),
            .n_o   (n_w[k+1])
        );
    end

    eft_color #(
        .NW (NW)
    ) u_color (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .lim        (lim),
        .tag_i      (tag_w[MAX_ITER_CELLS]),
        .n_i        (n_w[MAX_ITER_CELLS]),
        .out_valid  (out_valid),
        .out_col    (out_col),
        .out_row    (out_row),
        .iter_count (iter_count),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule
`default_nettype wire

// ===== hdl/eft_map.sv =====
`default_nettype none
module eft_map #(
    parameter int COORD_BITS = 12,
    parameter int NW         = 9
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_fire,
    input  wire logic [COORD_BITS-1:0]         col,
    input  wire logic [COORD_BITS-1:0]         row,
    input  wire logic [eft_pkg::VAL_W-1:0]     origin_re,
    input  wire logic [eft_pkg::VAL_W-1:0]     origin_im,
    input  wire logic [eft_pkg::STEP_W-1:0]    pixel_step,
    output eft_pkg::eft_tag_t                  tag_o,
    output logic [eft_pkg::VAL_W-1:0]          cre_o,
    output logic [eft_pkg::VAL_W-1:0]          cim_o,
    output logic [NW-1:0]                      n_o
);
    import eft_pkg::*;

    localparam int PW = COORD_BITS + STEP_W;

    eft_tag_t         tag_reg, tag_next;
    logic [PW-1:0]    dre_reg, dim_reg;
    eft_tag_t         tag2_reg;
    logic [VAL_W-1:0] cre_reg, cim_reg;
    logic signed [64:0] re_sum, im_sum;

    always_comb
    begin
        tag_next       = '0;
        tag_next.valid = in_fire;
        tag_next.col   = OUT_COORD_W'(col);
        tag_next.row   = OUT_COORD_W'(row);
    end

    always_comb
    begin
        re_sum = $signed({{33{origin_re[VAL_W-1]}}, origin_re}) + $signed(65'(dre_reg));
        im_sum = $signed({{33{origin_im[VAL_W-1]}}, origin_im}) - $signed(65'(dim_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg  <= '0;
            tag2_reg <= '0;
        end
        else if (en)
        begin
            tag_reg  <= tag_next;
            tag2_reg <= tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dre_reg <= PW'(col) * PW'(pixel_step);
            dim_reg <= PW'(row) * PW'(pixel_step);
            cre_reg <= sat32(re_sum);
            cim_reg <= sat32(im_sum);
        end
    end

    assign tag_o = tag2_reg;
    assign cre_o = cre_reg;
    assign cim_o = cim_reg;
    assign n_o   = '0;

endmodule
`default_nettype wire

// ===== hdl/eft_cell.sv =====
`default_nettype none
module eft_cell #(
    parameter int FRAC_BITS = 28,
    parameter int NW        = 9
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic [NW-1:0]             lim,
    input  wire eft_pkg::eft_tag_t         tag_i,
    input  wire logic [eft_pkg::VAL_W-1:0] cre_i,
    input  wire logic [eft_pkg::VAL_W-1:0] cim_i,
    input  wire logic [eft_pkg::VAL_W-1:0] zre_i,
    input  wire logic [eft_pkg::VAL_W-1:0] zim_i,
    input  wire logic [NW-1:0]             n_i,
    output eft_pkg::eft_tag_t              tag_o,
    output logic [eft_pkg::VAL_W-1:0]      cre_o,
    output logic [eft_pkg::VAL_W-1:0]      cim_o,
    output logic [eft_pkg::VAL_W-1:0]      zre_o,
    output logic [eft_pkg::VAL_W-1:0]      zim_o,
    output logic [NW-1:0]                  n_o
);
    import eft_pkg::*;

    localparam int ESC_SHIFT   = 2 * FRAC_BITS + 2;
    localparam bit ESC_ALWAYS  = (ESC_SHIFT >= 64);
    localparam logic [64:0] ESC_LIM = ESC_ALWAYS ? 65'd0 : (65'd1 << ESC_SHIFT);

    // First half: the two squares and the cross product.
    eft_tag_t           tag_a_reg;
    logic [VAL_W-1:0]   cre_a_reg, cim_a_reg, zre_a_reg, zim_a_reg;
    logic [NW-1:0]      n_a_reg;
    logic signed [63:0] xx_reg, yy_reg, xy_reg;

    // Second half: escape test and update.
    eft_tag_t           tag_b_reg, tag_b_next;
    logic [VAL_W-1:0]   cre_b_reg, cim_b_reg, zre_b_reg, zim_b_reg;
    logic [VAL_W-1:0]   zre_b_next, zim_b_next;
    logic [NW-1:0]      n_b_reg, n_b_next;

    logic [64:0]        mag;
    logic               bounded;
    logic signed [63:0] diff, re_sh, im_sh;

    always_comb
    begin
        mag     = {1'b0, xx_reg} + {1'b0, yy_reg};
        bounded = ESC_ALWAYS || (mag <= ESC_LIM);
        diff    = xx_reg - yy_reg;
        re_sh   = diff >>> FRAC_BITS;
        im_sh   = xy_reg >>> (FRAC_BITS - 1);
        tag_b_next = tag_a_reg;
        zre_b_next = zre_a_reg;
        zim_b_next = zim_a_reg;
        n_b_next   = n_a_reg;
        if (!tag_a_reg.done)
        begin
            if (!bounded || n_a_reg >= lim)
                tag_b_next.done = 1'b1;
            else
            begin
                zre_b_next = sat32($signed({re_sh[63], re_sh})
                                   + $signed({{33{cre_a_reg[VAL_W-1]}}, cre_a_reg}));
                zim_b_next = sat32($signed({im_sh[63], im_sh})
                                   + $signed({{33{cim_a_reg[VAL_W-1]}}, cim_a_reg}));
                n_b_next   = n_a_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else if (en)
        begin
            tag_a_reg <= tag_i;
            tag_b_reg <= tag_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cre_a_reg <= cre_i;
            cim_a_reg <= cim_i;
            zre_a_reg <= zre_i;
            zim_a_reg <= zim_i;
            n_a_reg   <= n_i;
            xx_reg    <= $signed(zre_i) * $signed(zre_i);
            yy_reg    <= $signed(zim_i) * $signed(zim_i);
            xy_reg    <= $signed(zre_i) * $signed(zim_i);
            cre_b_reg <= cre_a_reg;
            cim_b_reg <= cim_a_reg;
            zre_b_reg <= zre_b_next;
            zim_b_reg <= zim_b_next;
            n_b_reg   <= n_b_next;
        end
    end

    assign tag_o = tag_b_reg;
    assign cre_o = cre_b_reg;
    assign cim_o = cim_b_reg;
    assign zre_o = zre_b_reg;
    assign zim_o = zim_b_reg;
    assign n_o   = n_b_reg;

endmodule
`default_nettype wire

// ===== hdl/eft_color.sv =====
`default_nettype none
module eft_color #(
    parameter int NW = 9
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic [NW-1:0]                lim,
    input  wire eft_pkg::eft_tag_t            tag_i,
    input  wire logic [NW-1:0]                n_i,
    output logic                              out_valid,
    output logic [eft_pkg::OUT_COORD_W-1:0]   out_col,
    output logic [eft_pkg::OUT_COORD_W-1:0]   out_row,
    output logic [eft_pkg::ITER_W-1:0]        iter_count,
    output logic [eft_pkg::COLOR_W-1:0]       red,
    output logic [eft_pkg::COLOR_W-1:0]       green,
    output logic [eft_pkg::COLOR_W-1:0]       blue
);
    import eft_pkg::*;

    localparam int RW = NW + DIV_STEPS;

    // Restoring division of 256*n by the limit, one quotient bit per stage.
    eft_tag_t               tag_reg [0:DIV_STEPS];
    logic [NW-1:0]          n_reg   [0:DIV_STEPS];
    logic [RW-1:0]          rem_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0]   q_reg   [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg[0] <= '0;
        else if (en)
            tag_reg[0] <= tag_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]   <= n_i;
            rem_reg[0] <= RW'(n_i) << 8;
            q_reg[0]   <= '0;
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        localparam int SH = DIV_STEPS - 1 - s;
        logic [RW-1:0] dvs;
        logic          ge;
        assign dvs = RW'(lim) << SH;
        assign ge  = rem_reg[s] >= dvs;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[s+1] <= '0;
            else if (en)
                tag_reg[s+1] <= tag_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s+1]   <= n_reg[s];
                rem_reg[s+1] <= ge ? rem_reg[s] - dvs : rem_reg[s];
                q_reg[s+1]   <= q_reg[s] | (ge ? DIV_STEPS'(1) << SH : '0);
            end
        end
    end

    logic                   valid_reg;
    logic [OUT_COORD_W-1:0] col_reg, row_reg;
    logic [ITER_W-1:0]      iter_reg;
    logic [COLOR_W-1:0]     red_reg, green_reg, blue_reg;
    logic [DIV_STEPS-1:0]   q;
    logic [DIV_STEPS:0]     g_sum, b_val;

    always_comb
    begin
        q     = q_reg[DIV_STEPS];
        g_sum = 10'd128 + 10'(q >> 1);
        // 256 minus the quotient rounded up.
        b_val = 10'd256 - 10'(q) - 10'(rem_reg[DIV_STEPS] != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= tag_reg[DIV_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg   <= tag_reg[DIV_STEPS].col;
            row_reg   <= tag_reg[DIV_STEPS].row;
            iter_reg  <= ITER_W'(n_reg[DIV_STEPS]);
            red_reg   <= (q > 9'd255) ? COLOR_MAX : q[COLOR_W-1:0];
            green_reg <= (g_sum > 10'd255) ? COLOR_MAX : g_sum[COLOR_W-1:0];
            blue_reg  <= (b_val > 10'd255) ? COLOR_MAX : b_val[COLOR_W-1:0];
        end
    end

    assign out_valid  = valid_reg;
    assign out_col    = col_reg;
    assign out_row    = row_reg;
    assign iter_count = iter_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;

    // A pixel that never iterated gets no red and full blue.
    a_zero_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        (en && tag_reg[DIV_STEPS].valid && n_reg[DIV_STEPS] == '0)
        |=> (red_reg == '0 && blue_reg == COLOR_MAX))
        else $error("zero count gave wrong color");

    // A pixel that hit the limit gets no blue.
    a_full_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        (en && tag_reg[DIV_STEPS].valid && n_reg[DIV_STEPS] == lim)
        |=> (blue_reg == '0 && red_reg == COLOR_MAX))
        else $error("full count gave wrong color");

    // The quotient never exceeds 256 since the count never exceeds the limit.
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg[DIV_STEPS].valid |-> (q_reg[DIV_STEPS] <= 9'd256))
        else $error("ramp quotient out of range");

endmodule
`default_nettype wire
